>>> sv/aps_pkg.sv
`default_nettype none

package aps_pkg;

   // Register indexes on the control port
   localparam logic [2:0] CSR_PEAK_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_MIN_STEP_GAP   = 3'd1;
   localparam logic [2:0] CSR_MAX_STEP_GAP   = 3'd2;
   localparam logic [2:0] CSR_RUN_TIMEOUT    = 3'd3;
   localparam logic [2:0] CSR_ENTRY_STEPS    = 3'd4;
   localparam logic [2:0] CSR_BASELINE_GAIN  = 3'd5;

   // Register reset values
   localparam logic [15:0] PEAK_THRESHOLD_RST = 16'd900;
   localparam logic [15:0] MIN_STEP_GAP_RST   = 16'd280;
   localparam logic [15:0] MAX_STEP_GAP_RST   = 16'd1000;
   localparam logic [15:0] RUN_TIMEOUT_RST    = 16'd1400;
   localparam logic [3:0]  ENTRY_STEPS_RST    = 4'd4;
   localparam logic [15:0] BASELINE_GAIN_RST  = 16'd2621;

   // Gravity baseline after reset: 8192.0 in Q16.16
   localparam logic [31:0] BASELINE_RST = 32'd536870912;

   // First trial bit of the square root (1 << 30)
   localparam logic [31:0] ROOT_BIT_START = 32'h4000_0000;

   typedef struct packed {
      logic [15:0] peak_threshold;
      logic [15:0] min_step_gap_ms;
      logic [15:0] max_step_gap_ms;
      logic [15:0] run_timeout_ms;
      logic [3:0]  entry_steps;
      logic [15:0] baseline_gain;
   } cfg_type;

   // Classified sample handed from front to back
   typedef struct packed {
      logic [15:0] magnitude;
      logic [31:0] sample_time_ms;
   } meas_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_SQUARE,
      FRONT_ROOT,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_BASE,
      BACK_STEP
   } back_state_type;

endpackage

`default_nettype wire

>>> sv/aps_if.sv
`default_nettype none

// Sample channel
interface aps_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic [31:0]        sample_time_ms;

   modport source (output valid, accel_x, accel_y, accel_z, sample_time_ms, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, sample_time_ms, output ready);
endinterface

// Result channel
interface aps_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] step_total;
   logic [3:0]  steps_added;
   logic [15:0] magnitude;
   logic        above_peak;

   modport source (output valid, step_total, steps_added, magnitude, above_peak, input ready);
   modport sink   (input valid, step_total, steps_added, magnitude, above_peak, output ready);
endinterface

// Register write channel
interface aps_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/aps_front.sv
`default_nettype none

// Front: takes a sample, sums the squared axes with one squarer, then
// extracts the floor square root four bits of trial per cycle.
module aps_front (
   input  logic                clock,
   input  logic                reset,
   aps_req_if.sink             req,
   output logic                meas_valid,
   input  logic                meas_ready,
   output aps_pkg::meas_type   meas
);

   localparam logic [1:0] SQUARE_LAST = 2'd2;
   localparam logic [1:0] ROOT_LAST   = 2'd3;

   aps_pkg::front_state_type state_ff, state_in;

   logic [1:0]         cnt_ff, cnt_in;
   logic signed [15:0] ax_ff, ax_in;
   logic signed [15:0] ay_ff, ay_in;
   logic signed [15:0] az_ff, az_in;
   logic [31:0]        time_ff, time_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        root_ff, root_in;
   logic [31:0]        bit_ff, bit_in;
   logic [15:0]        mag_ff, mag_in;

   logic signed [31:0] sq;
   logic [31:0]        sum_sq;
   logic [31:0]        rem_step, root_step, bit_step;
   logic               accept;

   assign accept = req.valid && req.ready;

   // One square per cycle; axes rotate through ax_ff
   assign sq     = ax_ff * ax_ff;
   assign sum_sq = acc_ff + unsigned'(sq);

   // Four digit-by-digit root steps
   always_comb begin
      logic [31:0] v;
      logic [31:0] r;
      logic [31:0] b;
      v = rem_ff;
      r = root_ff;
      b = bit_ff;
      for (int i = 0; i < 4; i++) begin
         if ({1'b0, v} >= ({1'b0, r} + {1'b0, b})) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      rem_step  = v;
      root_step = r;
      bit_step  = b;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aps_pkg::FRONT_IDLE: begin
            if (accept) state_in = aps_pkg::FRONT_SQUARE;
         end
         aps_pkg::FRONT_SQUARE: begin
            if (cnt_ff == SQUARE_LAST) state_in = aps_pkg::FRONT_ROOT;
         end
         aps_pkg::FRONT_ROOT: begin
            if (cnt_ff == ROOT_LAST) state_in = aps_pkg::FRONT_PUSH;
         end
         aps_pkg::FRONT_PUSH: begin
            if (meas_ready) state_in = aps_pkg::FRONT_IDLE;
         end
         default: state_in = aps_pkg::FRONT_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req.ready  = 1'b0;
      meas_valid = 1'b0;
      case (state_ff)
         aps_pkg::FRONT_IDLE: req.ready  = 1'b1;
         aps_pkg::FRONT_PUSH: meas_valid = 1'b1;
         default: begin
            req.ready  = 1'b0;
            meas_valid = 1'b0;
         end
      endcase
   end

   assign meas.magnitude      = mag_ff;
   assign meas.sample_time_ms = time_ff;

   // Datapath
   always_comb begin
      cnt_in  = cnt_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      az_in   = az_ff;
      time_in = time_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      mag_in  = mag_ff;
      case (state_ff)
         aps_pkg::FRONT_IDLE: begin
            if (accept) begin
               ax_in   = req.accel_x;
               ay_in   = req.accel_y;
               az_in   = req.accel_z;
               time_in = req.sample_time_ms;
               acc_in  = '0;
               cnt_in  = '0;
            end
         end
         aps_pkg::FRONT_SQUARE: begin
            ax_in  = ay_ff;
            ay_in  = az_ff;
            acc_in = sum_sq;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == SQUARE_LAST) begin
               rem_in  = sum_sq;
               root_in = '0;
               bit_in  = aps_pkg::ROOT_BIT_START;
               cnt_in  = '0;
            end
         end
         aps_pkg::FRONT_ROOT: begin
            rem_in  = rem_step;
            root_in = root_step;
            bit_in  = bit_step;
            cnt_in  = cnt_ff + 2'd1;
            if (cnt_ff == ROOT_LAST) mag_in = root_step[15:0];
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aps_pkg::FRONT_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      az_ff   <= az_in;
      time_ff <= time_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      mag_ff  <= mag_in;
   end

endmodule

`default_nettype wire

>>> sv/aps_fifo.sv
`default_nettype none

// Short queue between front and back
module aps_fifo #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  aps_pkg::meas_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output aps_pkg::meas_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   aps_pkg::meas_type mem_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule

`default_nettype wire

>>> sv/aps_back.sv
`default_nettype none

// Back: baseline update, peak detection, rhythm tracking, result register
module aps_back (
   input  logic              clock,
   input  logic              reset,
   input  aps_pkg::cfg_type  cfg,
   input  logic              meas_valid,
   output logic              meas_ready,
   input  aps_pkg::meas_type meas,
   aps_rsp_if.source         rsp
);

   aps_pkg::back_state_type state_ff, state_in;

   logic [15:0]        mag_ff, mag_in;
   logic [31:0]        time_ff, time_in;
   logic signed [49:0] prod_ff, prod_in;
   logic [31:0]        base_ff, base_in;
   logic               in_peak_ff, in_peak_in;
   logic [31:0]        last_ff, last_in;
   logic [3:0]         run_ff, run_in;
   logic [31:0]        count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_total_ff, rsp_total_in;
   logic [3:0]         rsp_added_ff, rsp_added_in;
   logic [15:0]        rsp_mag_ff, rsp_mag_in;
   logic               rsp_peak_ff, rsp_peak_in;

   logic [31:0]        m;
   logic signed [32:0] diff;
   logic signed [16:0] gain_s;
   logic signed [49:0] prod;
   logic signed [34:0] nb_sum;
   logic [31:0]        nb_clamped;
   logic signed [33:0] dev;
   logic signed [33:0] thr_open, thr_close;
   logic [31:0]        gap;
   logic [3:0]         entry;
   logic [3:0]         run_eff;
   logic [3:0]         run_next;
   logic               enter, leave, in_window;
   logic [3:0]         added;
   logic               out_free, pop;

   assign pop      = meas_valid && meas_ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Q16.16 magnitude and gain product
   assign m      = {mag_ff, 16'h0000};
   assign diff   = $signed({1'b0, m}) - $signed({1'b0, base_ff});
   assign gain_s = $signed({1'b0, cfg.baseline_gain});
   assign prod   = gain_s * diff;

   // New baseline: old baseline plus floor of product / 65536, kept within 32 bits
   assign nb_sum = $signed({3'b000, base_ff}) + 35'(prod_ff >>> 16);
   always_comb begin
      if (nb_sum < 0)                  nb_clamped = '0;
      else if (nb_sum[34:32] != 3'b000) nb_clamped = '1;
      else                             nb_clamped = nb_sum[31:0];
   end

   // Peak hysteresis against the updated baseline
   assign dev       = $signed({2'b00, m}) - $signed({2'b00, base_ff});
   assign thr_open  = $signed({2'b00, cfg.peak_threshold, 16'h0000});
   assign thr_close = $signed({3'b000, cfg.peak_threshold[15:1], 16'h0000});
   assign enter     = !in_peak_ff && (dev > thr_open);
   assign leave     = in_peak_ff && (dev < thr_close);

   // Rhythm run
   assign gap       = time_ff - last_ff;
   assign entry     = (cfg.entry_steps == 4'd0) ? 4'd1 : cfg.entry_steps;
   assign run_eff   = ((run_ff != 4'd0) && (gap > {16'h0000, cfg.run_timeout_ms})) ?
                      4'd0 : run_ff;
   assign in_window = (gap >= {16'h0000, cfg.min_step_gap_ms}) &&
                      (gap <= {16'h0000, cfg.max_step_gap_ms});

   always_comb begin
      run_next = run_eff;
      added    = 4'd0;
      if (enter) begin
         if (in_window) begin
            if (run_eff < entry) begin
               run_next = run_eff + 4'd1;
               if (run_next == entry) added = entry;
            end else begin
               added = 4'd1;
            end
         end else begin
            run_next = 4'd1;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aps_pkg::BACK_IDLE: if (meas_valid) state_in = aps_pkg::BACK_MUL;
         aps_pkg::BACK_MUL:  state_in = aps_pkg::BACK_BASE;
         aps_pkg::BACK_BASE: state_in = aps_pkg::BACK_STEP;
         aps_pkg::BACK_STEP: if (out_free) state_in = aps_pkg::BACK_IDLE;
         default:            state_in = aps_pkg::BACK_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      case (state_ff)
         aps_pkg::BACK_IDLE: meas_ready = 1'b1;
         default:            meas_ready = 1'b0;
      endcase
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.step_total  = rsp_total_ff;
   assign rsp.steps_added = rsp_added_ff;
   assign rsp.magnitude   = rsp_mag_ff;
   assign rsp.above_peak  = rsp_peak_ff;

   // Datapath and detector state
   always_comb begin
      mag_in       = mag_ff;
      time_in      = time_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;
      in_peak_in   = in_peak_ff;
      last_in      = last_ff;
      run_in       = run_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_total_in = rsp_total_ff;
      rsp_added_in = rsp_added_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_peak_in  = rsp_peak_ff;
      case (state_ff)
         aps_pkg::BACK_IDLE: begin
            if (pop) begin
               mag_in  = meas.magnitude;
               time_in = meas.sample_time_ms;
            end
         end
         aps_pkg::BACK_MUL:  prod_in = prod;
         aps_pkg::BACK_BASE: base_in = nb_clamped;
         aps_pkg::BACK_STEP: begin
            if (out_free) begin
               run_in = run_next;
               if (enter) begin
                  in_peak_in = 1'b1;
                  last_in    = time_ff;
                  count_in   = count_ff + {28'h0000000, added};
               end else if (leave) begin
                  in_peak_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               rsp_total_in = enter ? count_ff + {28'h0000000, added} : count_ff;
               rsp_added_in = added;
               rsp_mag_in   = mag_ff;
               rsp_peak_in  = enter ? 1'b1 : (leave ? 1'b0 : in_peak_ff);
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp.ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aps_pkg::BACK_IDLE;
         base_ff      <= aps_pkg::BASELINE_RST;
         in_peak_ff   <= 1'b0;
         last_ff      <= '0;
         run_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         in_peak_ff   <= in_peak_in;
         last_ff      <= last_in;
         run_ff       <= run_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      time_ff      <= time_in;
      prod_ff      <= prod_in;
      rsp_total_ff <= rsp_total_in;
      rsp_added_ff <= rsp_added_in;
      rsp_mag_ff   <= rsp_mag_in;
      rsp_peak_ff  <= rsp_peak_in;
   end

endmodule

`default_nettype wire

>>> sv/accel_peak_step_detector_core.sv
// The front takes one sample at a time and, while results are taken, sets the throughput:
// each sample passes the shared squarer, then the square root unit, then the push into
// the queue. The back overlaps with the front and handles one sample at a time in its
// multiply, baseline and step states.
// Reset (synchronous, active high): empties front, queue and result register,
// loads register defaults, baseline 8192.0, clears peak, run and step total.
`default_nettype none

module accel_peak_step_detector_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   aps_req_if.sink   req_bus,
   aps_rsp_if.source rsp_bus,
   aps_csr_if.sink   csr_bus
);

   aps_pkg::cfg_type  cfg_ff, cfg_in;
   aps_pkg::meas_type front_meas, queue_meas;
   logic              front_valid, front_ready;
   logic              queue_valid, queue_ready;
   logic [3:0]        entry_eff;

   // Register writes are always taken
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            aps_pkg::CSR_PEAK_THRESHOLD: cfg_in.peak_threshold  = csr_bus.data;
            aps_pkg::CSR_MIN_STEP_GAP:   cfg_in.min_step_gap_ms = csr_bus.data;
            aps_pkg::CSR_MAX_STEP_GAP:   cfg_in.max_step_gap_ms = csr_bus.data;
            aps_pkg::CSR_RUN_TIMEOUT:    cfg_in.run_timeout_ms  = csr_bus.data;
            aps_pkg::CSR_ENTRY_STEPS:    cfg_in.entry_steps     = csr_bus.data[3:0];
            aps_pkg::CSR_BASELINE_GAIN:  cfg_in.baseline_gain   = csr_bus.data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peak_threshold  <= aps_pkg::PEAK_THRESHOLD_RST;
         cfg_ff.min_step_gap_ms <= aps_pkg::MIN_STEP_GAP_RST;
         cfg_ff.max_step_gap_ms <= aps_pkg::MAX_STEP_GAP_RST;
         cfg_ff.run_timeout_ms  <= aps_pkg::RUN_TIMEOUT_RST;
         cfg_ff.entry_steps     <= aps_pkg::ENTRY_STEPS_RST;
         cfg_ff.baseline_gain   <= aps_pkg::BASELINE_GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   aps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .meas_valid (front_valid),
      .meas_ready (front_ready),
      .meas       (front_meas)
   );

   aps_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_meas),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_meas)
   );

   aps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .meas_valid (queue_valid),
      .meas_ready (queue_ready),
      .meas       (queue_meas),
      .rsp        (rsp_bus)
   );

   assign entry_eff = (cfg_ff.entry_steps == 4'd0) ? 4'd1 : cfg_ff.entry_steps;

   // Front works on one sample at a time
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("sample beat taken while front busy");

   // Credited steps are none, one or the whole entry run
   a_added_values: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.steps_added == 4'd0 || rsp_bus.steps_added == 4'd1 ||
                         rsp_bus.steps_added == entry_eff))
      else $error("unexpected steps_added");

   // Steps are only credited on a peak entry
   a_added_in_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.steps_added != 4'd0 |-> rsp_bus.above_peak)
      else $error("steps credited outside a peak");

endmodule

`default_nettype wire
